// ===== design/tqvu_pkg.sv =====
`timescale 1ns / 1ps

package tqvu_pkg;

  // Table geometry; both counts are powers of two, so indices wrap by masking
  localparam int STATE_COUNT  = 1024;
  localparam int ACTION_COUNT = 8;
  localparam int STATE_W      = $clog2(STATE_COUNT);
  localparam int ACT_W        = $clog2(ACTION_COUNT);
  localparam int ADDR_W       = STATE_W + ACT_W;
  localparam int DEPTH        = STATE_COUNT * ACTION_COUNT;

  // Beat field widths
  localparam int STATE_FW = 10;
  localparam int ACT_FW   = 3;
  localparam int VAL_W    = 32;
  localparam int RATE_W   = 17;
  localparam int IN_W     = 72;
  localparam int OUT_W    = 64;

  // Q1.16 one, and discount after reset (0.95)
  localparam logic [RATE_W-1:0] ONE_Q16        = 17'd65536;
  localparam logic [RATE_W-1:0] DISCOUNT_RESET = 17'd62259;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  // State field wrapped onto the table rows
  function automatic logic [STATE_W-1:0] state_index(input logic [STATE_FW-1:0] s);
    logic [STATE_W+STATE_FW-1:0] w;
    w = {{STATE_W{1'b0}}, s};
    return w[STATE_W-1:0];
  endfunction

  // Action field wrapped onto the row entries
  function automatic logic [ACT_W-1:0] action_index(input logic [ACT_FW-1:0] a);
    logic [ACT_W+ACT_FW-1:0] w;
    w = {{ACT_W{1'b0}}, a};
    return w[ACT_W-1:0];
  endfunction

  // Rates above 1.0 are held at 1.0
  function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
    return (r > ONE_Q16) ? ONE_Q16 : r;
  endfunction

endpackage

// ===== design/tqvu_ram.sv =====
`timescale 1ns / 1ps

module tqvu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tabular_q_value_update.sv =====
`timescale 1ns / 1ps

// Tabular Q-learning value update over a STATE_COUNT x ACTION_COUNT table of
// signed Q16.16 values held in one RAM with a registered read port.
//
// Input stream (s_axis): one beat per transition; tlast is the episode end.
// Output stream (m_axis): one beat per input beat, in order, holding the
// saturated new value and the largest value found for the next state.
// Discount: user writes discount_we_i / discount_i while idle; not enforced.
//
// Sequence: the sequencer reads the ACTION_COUNT entries of the next state,
// then the old entry, one RAM read per cycle, then runs two registered
// multiplies and writes back. When tlast is set only the old entry is read
// and the best value is zero. Items are processed one at a time: a new beat
// is taken only after the last one has been written back.
//
// Reset: a clearing pass writes zero to every entry, one per cycle;
// s_axis_tready stays low until it ends. The discount returns to 0.95.
// Back-pressure: a result waits in the output register; the next beat may be
// taken meanwhile, but its write-back waits until the output slot is free.

module tabular_q_value_update (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // discount factor, unsigned Q1.16
  input  logic                         discount_we_i,
  input  logic [tqvu_pkg::RATE_W-1:0]  discount_i,
  // tdata: current_state[9:0], taken_action[12:10], reward[44:13],
  //        following_state[54:45], learning_rate[71:55]
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [tqvu_pkg::IN_W-1:0]    s_axis_tdata,
  input  logic                         s_axis_tlast,
  // tdata: new_value[31:0], best_next_value[63:32]
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [tqvu_pkg::OUT_W-1:0]   m_axis_tdata
);

  import tqvu_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_LAST  = 3'd3;
  localparam logic [2:0] S_DIFF  = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_UPD   = 3'd6;
  localparam logic [2:0] S_WR    = 3'd7;

  localparam logic [ACT_W:0]    RD_OLD   = (ACT_W+1)'(ACTION_COUNT);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

  // Control state
  logic [2:0]        state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [ACT_W:0]    rd_cnt_q, rd_cnt_d;
  logic              rd_vld_q, rd_vld_d;
  logic              rd_first_q, rd_first_d;
  logic              out_vld_q, out_vld_d;
  logic [RATE_W-1:0] discount_q;

  // Item payload
  logic [ADDR_W-1:0]        slot_q;
  logic [STATE_W-1:0]       next_q;
  logic signed [VAL_W-1:0]  reward_q;
  logic [RATE_W-1:0]        alpha_q;
  logic [RATE_W-1:0]        gamma_q;
  logic signed [VAL_W-1:0]  best_q;
  logic signed [VAL_W-1:0]  old_q;
  logic signed [49:0]       p1_q;
  logic signed [34:0]       diff_q;
  logic signed [52:0]       p2_q;
  logic signed [VAL_W-1:0]  new_q;
  logic [OUT_W-1:0]         out_data_q;

  // RAM port signals
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  // Datapath terms
  logic               in_acc;
  logic               out_free;
  logic signed [49:0] p1_d;
  logic signed [49:0] p1_rnd;
  logic signed [34:0] diff_d;
  logic signed [52:0] p2_d;
  logic signed [52:0] p2_rnd;
  logic signed [37:0] sum_d;
  logic signed [VAL_W-1:0] new_d;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;

  tqvu_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Read address: next-state row first, then the entry being updated
  assign ram_raddr = (rd_cnt_q == RD_OLD) ? slot_q : {next_q, rd_cnt_q[ACT_W-1:0]};

  // Write port: clearing pass or write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = new_q;
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (state_q == S_WR && out_free) begin
      ram_we = 1'b1;
    end
  end

  // Arithmetic: gamma*best, target minus old, alpha*diff, saturated sum
  assign p1_d   = $signed({1'b0, gamma_q}) * best_q;
  assign p1_rnd = p1_q + 50'sd32768;
  assign diff_d = 35'(reward_q) + 35'($signed(p1_rnd[49:16])) - 35'(old_q);
  assign p2_d   = $signed({1'b0, alpha_q}) * diff_q;
  assign p2_rnd = p2_q + 53'sd32768;
  assign sum_d  = 38'(old_q) + 38'($signed(p2_rnd[52:16]));

  always_comb begin
    if (sum_d[37:31] == {7{sum_d[37]}}) begin
      new_d = sum_d[31:0];
    end else if (sum_d[37]) begin
      new_d = VAL_MIN;
    end else begin
      new_d = VAL_MAX;
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    rd_cnt_d   = rd_cnt_q;
    rd_vld_d   = 1'b0;
    rd_first_d = 1'b0;
    out_vld_d  = out_vld_q;
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          rd_cnt_d = s_axis_tlast ? RD_OLD : '0;
          state_d  = S_READ;
        end
      end
      S_READ: begin
        rd_vld_d   = (rd_cnt_q != RD_OLD);
        rd_first_d = (rd_cnt_q == '0);
        rd_cnt_d   = rd_cnt_q + 1'b1;
        if (rd_cnt_q == RD_OLD) begin
          state_d = S_LAST;
        end
      end
      S_LAST:  state_d = S_DIFF;
      S_DIFF:  state_d = S_MUL;
      S_MUL:   state_d = S_UPD;
      S_UPD:   state_d = S_WR;
      S_WR: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      rd_cnt_q   <= '0;
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
      out_vld_q  <= 1'b0;
      discount_q <= DISCOUNT_RESET;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      rd_cnt_q   <= rd_cnt_d;
      rd_vld_q   <= rd_vld_d;
      rd_first_q <= rd_first_d;
      out_vld_q  <= out_vld_d;
      if (discount_we_i) begin
        discount_q <= discount_i;
      end
    end
  end

  // Payload capture and datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      slot_q   <= {state_index(s_axis_tdata[9:0]), action_index(s_axis_tdata[12:10])};
      reward_q <= s_axis_tdata[44:13];
      next_q   <= state_index(s_axis_tdata[54:45]);
      alpha_q  <= clamp_rate(s_axis_tdata[71:55]);
      gamma_q  <= clamp_rate(discount_q);
      best_q   <= '0;
    end else if (rd_vld_q && (rd_first_q || $signed(ram_rdata) > best_q)) begin
      best_q <= ram_rdata;
    end
    if (state_q == S_LAST) begin
      old_q <= ram_rdata;
      p1_q  <= p1_d;
    end
    if (state_q == S_DIFF) begin
      diff_q <= diff_d;
    end
    if (state_q == S_MUL) begin
      p2_q <= p2_d;
    end
    if (state_q == S_UPD) begin
      new_q <= new_d;
    end
    if (state_q == S_WR && out_free) begin
      out_data_q <= {best_q, new_q};
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== design/tqvu_checker.sv =====
`timescale 1ns / 1ps

module tqvu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Items taken in but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input taken while an item is still being worked");

  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 2'd0)
    else $error("result beat without a matching input beat");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two items in flight");

endmodule

bind tabular_q_value_update tqvu_checker u_tqvu_checker (.*);

// ===== tb/sv/tabular_q_value_update_test.sv =====
`timescale 1ns / 1ps

module tabular_q_value_update_test;

  // Transition beat, packed so that current_state lands in the lowest bits of tdata
  typedef struct packed {
    logic [tqvu_pkg::RATE_W-1:0]       learning_rate;
    logic [tqvu_pkg::STATE_FW-1:0]     following_state;
    logic signed [tqvu_pkg::VAL_W-1:0] reward;
    logic [tqvu_pkg::ACT_FW-1:0]       taken_action;
    logic [tqvu_pkg::STATE_FW-1:0]     current_state;
  } transition_t;

  // Result beat: new_value in the lowest bits
  typedef struct packed {
    logic signed [tqvu_pkg::VAL_W-1:0] best_next_value;
    logic signed [tqvu_pkg::VAL_W-1:0] new_value;
  } update_t;

  typedef struct {
    transition_t beat;
    logic        ended;
  } pending_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          discount_we_i;
  logic [tqvu_pkg::RATE_W-1:0]   discount_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [tqvu_pkg::IN_W-1:0]     s_axis_tdata;
  logic                          s_axis_tlast;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [tqvu_pkg::OUT_W-1:0]    m_axis_tdata;

  // Shadow of the value table and the discount register
  int                            value_table [tqvu_pkg::DEPTH];
  logic [tqvu_pkg::RATE_W-1:0]   discount_shadow;

  pending_t                      transitions [$];
  update_t                       expected_updates [$];
  int                            transitions_queued;
  int                            updates_seen;
  int                            mismatch_count;
  logic                          in_fire;
  bit                            idle_on;
  int                            send_gap;
  int                            ready_gap;
  int                            holdoff_left;
  bit                            holdoff_done;
  logic [tqvu_pkg::STATE_FW-1:0] hot_rows [16];

  tabular_q_value_update dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .discount_we_i (discount_we_i),
    .discount_i    (discount_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Divide by 2^16, round to nearest, ties upward
  function automatic longint q16_round(longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  // Q-learning update against the shadow table; returns the expected result beat
  function automatic update_t learn_step(transition_t t, logic ended);
    int     slot;
    int     row;
    longint alpha;
    longint gamma;
    longint best;
    longint target;
    longint old_v;
    longint upd;
    update_t res;
    slot   = int'(t.current_state) * tqvu_pkg::ACTION_COUNT + int'(t.taken_action);
    alpha  = (t.learning_rate > tqvu_pkg::ONE_Q16) ? longint'(tqvu_pkg::ONE_Q16)
                                                   : longint'(t.learning_rate);
    gamma  = (discount_shadow > tqvu_pkg::ONE_Q16) ? longint'(tqvu_pkg::ONE_Q16)
                                                   : longint'(discount_shadow);
    best   = 0;
    target = longint'($signed(t.reward));
    old_v  = longint'(value_table[slot]);
    // bootstrap from the row maximum, read before the write-back
    if (!ended) begin
      row  = int'(t.following_state) * tqvu_pkg::ACTION_COUNT;
      best = longint'(value_table[row]);
      for (int a = 1; a < tqvu_pkg::ACTION_COUNT; a++)
        if (longint'(value_table[row + a]) > best) best = longint'(value_table[row + a]);
      target = target + q16_round(gamma * best);
    end
    upd = old_v + q16_round(alpha * (target - old_v));
    if (upd > longint'(tqvu_pkg::VAL_MAX)) upd = longint'(tqvu_pkg::VAL_MAX);
    if (upd < longint'(tqvu_pkg::VAL_MIN)) upd = longint'(tqvu_pkg::VAL_MIN);
    value_table[slot]   = int'(upd);
    res.new_value       = upd[31:0];
    res.best_next_value = best[31:0];
    return res;
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatch_count < 50) $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  // Idle lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic queue_transition(int st, int act, int rew, int nxt, bit ended, int lr);
    pending_t p;
    p.beat.current_state   = st[tqvu_pkg::STATE_FW-1:0];
    p.beat.taken_action    = act[tqvu_pkg::ACT_FW-1:0];
    p.beat.reward          = rew;
    p.beat.following_state = nxt[tqvu_pkg::STATE_FW-1:0];
    p.beat.learning_rate   = lr[tqvu_pkg::RATE_W-1:0];
    p.ended                = ended;
    transitions.insert(transitions.size(), p);
    transitions_queued++;
  endtask

  // Random transitions, mostly over a few hot rows so that values build up
  task automatic run_random(int n);
    int st;
    int nxt;
    int rew;
    int lr;
    for (int k = 0; k < n; k++) begin
      st  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                        : int'(hot_rows[$urandom_range(0, 15)]);
      case ($urandom_range(0, 9))
        0:       nxt = st;
        1, 2:    nxt = $urandom_range(0, 1023);
        default: nxt = int'(hot_rows[$urandom_range(0, 15)]);
      endcase
      case ($urandom_range(0, 19))
        12, 13, 14, 15, 16: rew = int'($urandom);
        17:                 rew = int'(tqvu_pkg::VAL_MAX);
        18:                 rew = int'(tqvu_pkg::VAL_MIN);
        19:                 rew = 0;
        default:            rew = int'($urandom_range(0, 524288)) - 262144;
      endcase
      case ($urandom_range(0, 19))
        14, 15, 16, 17: lr = $urandom_range(0, 131071);
        18:             lr = int'(tqvu_pkg::ONE_Q16);
        19:             lr = $urandom_range(65537, 131071);
        default:        lr = $urandom_range(0, 65536);
      endcase
      queue_transition(st, $urandom_range(0, 7), rew, nxt, $urandom_range(0, 4) == 0, lr);
    end
    while (updates_seen < transitions_queued) @(negedge clk_i);
  endtask

  // Discount write while the block is idle
  task automatic set_discount(int v);
    @(negedge clk_i);
    discount_we_i   <= 1'b1;
    discount_i      <= v[tqvu_pkg::RATE_W-1:0];
    discount_shadow  = v[tqvu_pkg::RATE_W-1:0];
    @(negedge clk_i);
    discount_we_i   <= 1'b0;
  endtask

  // Stimulus and phase sequencing
  initial begin
    rst_ni             = 1'b0;
    discount_we_i      = 1'b0;
    discount_i         = '0;
    s_axis_tvalid      = 1'b0;
    s_axis_tdata       = '0;
    s_axis_tlast       = 1'b0;
    m_axis_tready      = 1'b0;
    discount_shadow    = tqvu_pkg::DISCOUNT_RESET;
    transitions_queued = 0;
    updates_seen       = 0;
    mismatch_count     = 0;
    in_fire            = 1'b0;
    idle_on            = 1'b1;
    send_gap           = 0;
    ready_gap          = 0;
    holdoff_left       = 0;
    holdoff_done       = 1'b0;
    hot_rows[0]        = '0;
    hot_rows[1]        = '1;
    for (int i = 2; i < 16; i++) hot_rows[i] = $urandom_range(0, 1023);
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, saturation both ways, same row, rate clamp, rounding ties
    queue_transition(0, 0, int'(tqvu_pkg::VAL_MAX), 1023, 1'b0, 65536);
    queue_transition(0, 1, int'(tqvu_pkg::VAL_MAX), 0, 1'b0, 65536);
    queue_transition(0, 2, 0, 0, 1'b0, 131071);
    queue_transition(0, 3, -1, 0, 1'b0, 0);
    for (int a = 0; a < 8; a++)
      queue_transition(1023, a, int'(tqvu_pkg::VAL_MIN), 1023, 1'b1, 65536);
    queue_transition(5, 4, int'(tqvu_pkg::VAL_MIN), 1023, 1'b0, 65536);
    queue_transition(1023, 0, 32'h1234_5678, 5, 1'b0, 1);
    queue_transition(512, 5, -32768, 0, 1'b1, 32768);
    queue_transition(512, 6, -32768, 0, 1'b1, 1);
    queue_transition(512, 7, 32768, 0, 1'b1, 1);
    queue_transition(700, 3, int'($urandom), 700, 1'b0, 65537);
    run_random(200);

    set_discount(int'(tqvu_pkg::ONE_Q16));
    run_random(210);
    set_discount(0);
    idle_on = 1'b0;
    run_random(210);
    idle_on = 1'b1;
    set_discount(131071);
    run_random(210);
    set_discount($urandom_range(1, 131071));
    run_random(210);

    repeat (3 * tqvu_pkg::ACTION_COUNT) @(negedge clk_i);
    if (expected_updates.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", expected_updates.size()));
    if (mismatch_count == 0) begin
      $display("tabular_q_value_update_test OK");
    end else begin
      $display("tabular_q_value_update_test NOT OK");
    end
    $finish;
  end

  // Transition driver
  always @(negedge clk_i) begin
    pending_t p;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else if (transitions.size() != 0) begin
        p = transitions.pop_front();
        s_axis_tdata  <= p.beat;
        s_axis_tlast  <= p.ended;
        s_axis_tvalid <= 1'b1;
        send_gap      <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // One long hold-off on the result side, while transitions keep coming
  always @(negedge clk_i) begin
    if (!holdoff_done && updates_seen >= 300) begin
      holdoff_left <= 400;
      holdoff_done <= 1'b1;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // Result-side ready with random stalls
  always @(negedge clk_i) begin
    if (holdoff_left != 0) begin
      m_axis_tready <= 1'b0;
    end else if (ready_gap != 0) begin
      m_axis_tready <= 1'b0;
      ready_gap     <= ready_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
      ready_gap     <= pick_gap();
    end
  end

  // Predict on each accepted transition, check each accepted result
  always @(posedge clk_i) begin
    update_t got;
    update_t want;
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_updates.insert(expected_updates.size(),
                                learn_step(s_axis_tdata, s_axis_tlast));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        updates_seen <= updates_seen + 1;
        if (expected_updates.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with none expected", updates_seen));
        end else begin
          want = expected_updates.pop_front();
          if (got.new_value !== want.new_value)
            flag_mismatch($sformatf("result %0d new_value %0d, expected %0d",
                                    updates_seen, got.new_value, want.new_value));
          if (got.best_next_value !== want.best_next_value)
            flag_mismatch($sformatf("result %0d best_next_value %0d, expected %0d",
                                    updates_seen, got.best_next_value,
                                    want.best_next_value));
        end
      end
    end
  end

  // Watchdog
  initial begin
    #6_000_000;
    $display("tabular_q_value_update_test NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tqvu_pkg.sv
design/tqvu_ram.sv
design/tabular_q_value_update.sv
design/tqvu_checker.sv
tb/sv/tabular_q_value_update_test.sv
